### sv/mcuc_pkg.sv
// Shared constants and types for the Monte Carlo unit-circle counter.
// The hash constants, field widths, CSR map and the controller command bundle live here.
// No dependencies.
`default_nettype none

package mcuc_pkg;

   // hash finalizer constants
   localparam logic [63:0] MIX_M1 = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_M2 = 64'h94d049bb133111eb;
   localparam int MIX1_SHIFT = 30;
   localparam int MIX2_SHIFT = 27;
   localparam int FIN_SHIFT  = 31;
   localparam int DROP_BITS  = 11;

   localparam int SEED_W      = 64;
   localparam int INDEX_W     = 48;
   localparam int COORD_W     = 54;
   localparam int COUNT_OUT_W = 49;
   localparam int SQ_W        = 108;

   // 1.0 with 53 fraction bits, and 1.0 squared with 106 fraction bits
   localparam logic [COORD_W-1:0] FRAC_ONE  = 54'h20000000000000;
   localparam logic [SQ_W-1:0]    HIT_LIMIT = 108'd1 << 106;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 160;
   localparam int RSP_PAD_W  = RSP_DATA_W - (2 * COORD_W + 1 + COUNT_OUT_W);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEED_ADDR = 3'd0;
   localparam logic [SEED_W-1:0]     SEED_RESET    = 64'd2026;

   typedef struct packed {
      logic load;        // capture a new item
      logic mix_mul;     // partial products of a hash round
      logic mix_second;  // select second hash round
      logic mix_add;     // fold partial products into the hash word
      logic fin;         // final xor-shift, coordinate and magnitude
      logic sq_mul;      // partial products of the magnitude square
      logic sq_add;      // assemble the square
      logic emit;        // load the result register and update the count
   } mcuc_cmd_type;

endpackage

`default_nettype wire

### sv/mcuc_lane.sv
// One coordinate lane: splitmix64 finalizer and exact square of the magnitude.
// Three 32x32 multipliers are shared between the hash rounds and the square.
// Depends on mcuc_pkg.
`default_nettype none

module mcuc_lane (
   input  wire                           clock,
   input  mcuc_pkg::mcuc_cmd_type        cmd,
   input  wire  [mcuc_pkg::SEED_W-1:0]   base,
   output logic signed [mcuc_pkg::COORD_W-1:0] point,
   output logic [mcuc_pkg::SQ_W-1:0]     sq
);
   import mcuc_pkg::*;

   localparam int U_W = SEED_W - DROP_BITS;

   logic [SEED_W-1:0]  v_ff, v_in;
   logic [63:0]        p0_ff, p1_ff, p2_ff;
   logic [63:0]        p0_in, p1_in, p2_in;
   logic signed [COORD_W-1:0] point_ff, point_in;
   logic [COORD_W-1:0] mag_ff, mag_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;

   logic [SEED_W-1:0]  mix_word, mix_const, fin_word;
   logic [U_W-1:0]     u;
   logic [COORD_W-1:0] twice_u;
   logic [31:0]        mag_lo, mag_hi;
   logic [31:0]        a0, b0, a1, b1, a2, b2;

   assign mix_word  = cmd.mix_second ? (v_ff ^ (v_ff >> MIX2_SHIFT))
                                     : (v_ff ^ (v_ff >> MIX1_SHIFT));
   assign mix_const = cmd.mix_second ? MIX_M2 : MIX_M1;

   assign mag_lo = mag_ff[31:0];
   assign mag_hi = 32'(mag_ff[COORD_W-1:32]);

   always_comb begin
      if (cmd.sq_mul) begin
         a0 = mag_lo; b0 = mag_lo;
         a1 = mag_lo; b1 = mag_hi;
         a2 = mag_hi; b2 = mag_hi;
      end else begin
         a0 = mix_word[31:0];  b0 = mix_const[31:0];
         a1 = mix_word[31:0];  b1 = mix_const[63:32];
         a2 = mix_word[63:32]; b2 = mix_const[31:0];
      end
   end

   assign p0_in = 64'(a0) * 64'(b0);
   assign p1_in = 64'(a1) * 64'(b1);
   assign p2_in = 64'(a2) * 64'(b2);

   // low 64 bits of the full product
   assign v_in = p0_ff + {p1_ff[31:0] + p2_ff[31:0], 32'h0};

   assign fin_word = v_ff ^ (v_ff >> FIN_SHIFT);
   assign u        = fin_word[SEED_W-1:DROP_BITS];
   assign twice_u  = {1'b0, u[U_W-2:0], 1'b0};
   assign point_in = {~u[U_W-1], u[U_W-2:0], 1'b0};
   assign mag_in   = u[U_W-1] ? twice_u : (FRAC_ONE - twice_u);

   // m^2 = hi^2 << 64 + (hi*lo) << 33 + lo^2
   assign sq_in = {p2_ff[43:0], p0_ff} + {21'b0, p1_ff[53:0], 33'b0};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         v_ff <= base;
      end else if (cmd.mix_add) begin
         v_ff <= v_in;
      end
      if (cmd.mix_mul || cmd.sq_mul) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (cmd.fin) begin
         point_ff <= point_in;
         mag_ff   <= mag_in;
      end
      if (cmd.sq_add) begin
         sq_ff <= sq_in;
      end
   end

   assign point = point_ff;
   assign sq    = sq_ff;

endmodule

`default_nettype wire

### sv/mcuc_dpath.sv
// Datapath: base formation, two coordinate lanes, circle test, hit counter, result register.
// Driven by the command bundle from mcuc_ctrl.
// Depends on mcuc_pkg and mcuc_lane.
`default_nettype none

module mcuc_dpath #(
   parameter int INDEX_BITS = 48
) (
   input  wire                              clock,
   input  wire                              reset,
   input  mcuc_pkg::mcuc_cmd_type           cmd,
   input  wire  [mcuc_pkg::SEED_W-1:0]      seed,
   input  wire  [mcuc_pkg::INDEX_W-1:0]     sample_index,
   input  wire                              last_sample,
   output logic [mcuc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);
   import mcuc_pkg::*;

   localparam int CNT_W = INDEX_BITS + 1;
   localparam logic [SEED_W-1:0] IDX_MASK = (64'd1 << INDEX_BITS) - 64'd1;

   logic [SEED_W-1:0] idx_word, twice_idx, base_x, base_y;
   logic signed [COORD_W-1:0] point_x, point_y;
   logic [SQ_W-1:0]   sq_x, sq_y, sq_sum;
   logic              hit;
   logic [CNT_W-1:0]  count_ff, count_in, count_next;
   logic              last_ff;

   logic [COORD_W-1:0]     out_x_ff, out_y_ff;
   logic                   out_hit_ff, out_last_ff;
   logic [COUNT_OUT_W-1:0] out_count_ff;

   assign idx_word  = SEED_W'(sample_index) & IDX_MASK;
   assign twice_idx = {idx_word[SEED_W-2:0], 1'b0};
   assign base_x    = seed + twice_idx;
   assign base_y    = seed + (twice_idx | 64'd1);

   mcuc_lane u_lane_x (
      .clock (clock),
      .cmd   (cmd),
      .base  (base_x),
      .point (point_x),
      .sq    (sq_x)
   );

   mcuc_lane u_lane_y (
      .clock (clock),
      .cmd   (cmd),
      .base  (base_y),
      .point (point_y),
      .sq    (sq_y)
   );

   // on the circle counts as inside
   assign sq_sum     = sq_x + sq_y;
   assign hit        = (sq_sum <= HIT_LIMIT);
   assign count_next = count_ff + CNT_W'(hit);

   always_comb begin
      count_in = count_ff;
      if (cmd.emit) begin
         count_in = last_ff ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         last_ff <= last_sample;
      end
      if (cmd.emit) begin
         out_x_ff     <= point_x;
         out_y_ff     <= point_y;
         out_hit_ff   <= hit;
         out_count_ff <= COUNT_OUT_W'(count_next);
         out_last_ff  <= last_ff;
      end
   end

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, out_count_ff, out_hit_ff, out_y_ff, out_x_ff};
   assign rsp_tlast = out_last_ff;

endmodule

`default_nettype wire

### sv/mcuc_ctrl.sv
// Controller: sequences one sample through the hash rounds, square and result load.
// Owns the input ready and the result valid.
// Depends on mcuc_pkg.
`default_nettype none

module mcuc_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output mcuc_pkg::mcuc_cmd_type  cmd
);
   import mcuc_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_MIX1_MUL = 4'd1;
   localparam logic [3:0] ST_MIX1_ADD = 4'd2;
   localparam logic [3:0] ST_MIX2_MUL = 4'd3;
   localparam logic [3:0] ST_MIX2_ADD = 4'd4;
   localparam logic [3:0] ST_FIN      = 4'd5;
   localparam logic [3:0] ST_SQ_MUL   = 4'd6;
   localparam logic [3:0] ST_SQ_ADD   = 4'd7;
   localparam logic [3:0] ST_EMIT     = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MIX1_MUL;
            end
         end
         ST_MIX1_MUL: begin
            cmd.mix_mul = 1'b1;
            state_in    = ST_MIX1_ADD;
         end
         ST_MIX1_ADD: begin
            cmd.mix_add = 1'b1;
            state_in    = ST_MIX2_MUL;
         end
         ST_MIX2_MUL: begin
            cmd.mix_mul    = 1'b1;
            cmd.mix_second = 1'b1;
            state_in       = ST_MIX2_ADD;
         end
         ST_MIX2_ADD: begin
            cmd.mix_add = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_SQ_MUL;
         end
         ST_SQ_MUL: begin
            cmd.sq_mul = 1'b1;
            state_in   = ST_SQ_ADD;
         end
         ST_SQ_ADD: begin
            cmd.sq_add = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

### sv/monte_carlo_unit_circle_counter.sv
// Monte Carlo unit-circle hit counter.
// req channel: one transaction per sample; tdata holds the sample index, tlast marks
// the last sample of a batch. rsp channel: one transaction per sample with the point,
// the inside flag and the running hit count; tlast repeats the batch end.
// The seed register (byte address 0) sets the base of the hash; write it while idle.
// rsp_tvalid rises after the sample has passed base load, two serial 64-bit hash multiplies,
// finalize, the magnitude square and result load; each multiply and the square is a product
// step on three 32x32 multipliers per coordinate followed by an add step. The next sample is
// taken only once the previous one has loaded the result register.
// The hit count clears after the result of a sample marked last.
// A stalled rsp holds its transaction in the result register; the next sample is still
// taken and runs until its result is ready, then waits until the register frees.
// Reset: synchronous, active high; clears the sequencer, the result valid and the
// count, and sets the seed to 2026. No clearing pass is needed.
// Depends on mcuc_pkg, mcuc_ctrl, mcuc_dpath, mcuc_lane.
`default_nettype none

module monte_carlo_unit_circle_counter #(
   parameter int INDEX_BITS = 48
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // req_tdata: [47:0] sample_index
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [mcuc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire                                 req_tlast,
   // rsp_tdata: [53:0] point_x, [107:54] point_y, [108] inside_res,
   //            [157:109] inside_count, [159:158] zero
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [mcuc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [mcuc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [mcuc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mcuc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import mcuc_pkg::*;

   logic [SEED_W-1:0] seed_ff, seed_in;
   logic              seed_wr;
   mcuc_cmd_type      cmd;

   assign csr_pready = 1'b1;
   assign seed_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == CSR_SEED_ADDR);
   assign seed_in    = seed_wr ? csr_pwdata : seed_ff;
   assign csr_prdata = (csr_paddr == CSR_SEED_ADDR) ? seed_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mcuc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mcuc_dpath #(
      .INDEX_BITS (INDEX_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .seed         (seed_ff),
      .sample_index (req_tdata[INDEX_W-1:0]),
      .last_sample  (req_tlast),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire

### sv/mcuc_chk.sv
// Port-level assertions for the unit-circle counter, bound to the top level.
// Depends on mcuc_pkg.
`default_nettype none

module mcuc_chk (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   input  wire                             req_tready,
   input  wire                             rsp_tvalid,
   input  wire                             rsp_tready,
   input  wire  [mcuc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire                             rsp_tlast
);
   import mcuc_pkg::*;

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // one sample in flight: no second acceptance right after one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted back to back");

   // a valid result follows each acceptance
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##9 rsp_tvalid)
      else $error("rsp not valid after sample latency");

   // coordinates are 2u - 1 with u on a 2^-53 grid, so bit 0 is clear
   a_coord_even: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[0] && !rsp_tdata[COORD_W])
      else $error("odd coordinate on rsp");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind monte_carlo_unit_circle_counter mcuc_chk u_mcuc_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
